// ----- rtl/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the lru key-value cache: entry count,
// index and rank widths, request and response payloads, and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W  = IDX_W;
   localparam int COUNT_W = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int DATA_W  = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic {
      MODE_GET = 1'b0,
      MODE_PUT = 1'b1
   } mode_type;

   typedef struct packed {
      logic                     mode;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
   } rsp_type;

   localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;
   localparam logic signed [DATA_W-1:0] PUT_VALUE  = '0;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic match;
      logic commit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } dp_sts_type;

endpackage

// ----- rtl/lkvc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Controller for the lru key-value cache: sequences each item through a
// compare cycle and a commit cycle, and takes the next item on commit.
// ----------------------------------------------------------------------------
module lkvc_ctrl
   import lkvc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_MATCH  = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.load_req = 1'b0;
      cmd.match    = 1'b0;
      cmd.commit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            // commit only when the response register can take the item
            if (sts.out_free) begin
               cmd.commit   = 1'b1;
               req_ready    = 1'b1;
               cmd.load_req = req_valid;
               state_in     = req_valid ? ST_MATCH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/lkvc_datapath.sv -----
// ----------------------------------------------------------------------------
// lkvc_datapath
// Datapath for the lru key-value cache: entry lanes with parallel key
// compare, recency ranks, occupancy, capacity register and response register.
// ----------------------------------------------------------------------------
module lkvc_datapath
   import lkvc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       cmd,
   output dp_sts_type       sts,
   input  req_type          req_payload,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload
);

   logic [CAP_W-1:0]   cap_ff;
   logic [COUNT_W-1:0] occ_ff, occ_in;
   logic               valid_ff [ENTRIES];
   logic               valid_in [ENTRIES];
   logic [RANK_W-1:0]  rank_ff  [ENTRIES];
   logic [RANK_W-1:0]  rank_in  [ENTRIES];
   logic [DATA_W-1:0]  key_ff   [ENTRIES];
   logic [DATA_W-1:0]  value_ff [ENTRIES];

   req_type            req_ff;
   logic               hit_ff, hit_in;
   logic               evict_ff, evict_in;
   logic [IDX_W-1:0]   tgt_idx_ff, tgt_idx_in;
   logic [RANK_W-1:0]  tgt_rank_ff, tgt_rank_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [COUNT_W-1:0] eff_cap;
   logic [COUNT_W-1:0] occ_m1;
   logic [IDX_W-1:0]   hit_idx, victim_idx, free_idx;

   logic               wr_key;
   logic               wr_value;

   // ---------------- compare stage ----------------
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = COUNT_W'(1);
      end else if (COUNT_W'(cap_ff) > COUNT_W'(ENTRIES)) begin
         eff_cap = COUNT_W'(ENTRIES);
      end else begin
         eff_cap = COUNT_W'(cap_ff);
      end
   end

   assign occ_m1 = occ_ff - COUNT_W'(1);

   always_comb begin
      hit_in     = 1'b0;
      hit_idx    = '0;
      victim_idx = '0;
      free_idx   = '0;
      // scan downward so the lowest matching lane wins
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (key_ff[i] == req_ff.key)) begin
            hit_in  = 1'b1;
            hit_idx = IDX_W'(i);
         end
         // ranks of valid lanes are a permutation of 0..occ-1
         if (valid_ff[i] && (rank_ff[i] == occ_m1[RANK_W-1:0])) begin
            victim_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
      evict_in = (occ_ff >= eff_cap);
      if (hit_in) begin
         tgt_idx_in  = hit_idx;
         tgt_rank_in = rank_ff[hit_idx];
      end else if (evict_in) begin
         tgt_idx_in  = victim_idx;
         tgt_rank_in = occ_m1[RANK_W-1:0];
      end else begin
         tgt_idx_in  = free_idx;
         tgt_rank_in = '0;
      end
   end

   // ---------------- commit stage ----------------
   always_comb begin
      logic touch;
      logic insert;
      touch    = 1'b0;
      insert   = 1'b0;
      wr_key   = 1'b0;
      wr_value = 1'b0;
      occ_in   = occ_ff;
      rsp_in   = rsp_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
      end
      if (cmd.commit) begin
         if (req_ff.mode == MODE_GET) begin
            touch          = hit_ff;
            rsp_in.hit     = hit_ff;
            rsp_in.read_value = hit_ff ? $signed(value_ff[tgt_idx_ff]) : MISS_VALUE;
         end else begin
            rsp_in.hit        = hit_ff;
            rsp_in.read_value = PUT_VALUE;
            wr_value          = 1'b1;
            if (hit_ff) begin
               touch = 1'b1;
            end else if (evict_ff) begin
               touch  = 1'b1;
               wr_key = 1'b1;
            end else begin
               insert = 1'b1;
               wr_key = 1'b1;
               occ_in = occ_ff + COUNT_W'(1);
            end
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (touch && valid_ff[i] && (IDX_W'(i) != tgt_idx_ff)
                && (rank_ff[i] < tgt_rank_ff)) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
            if (insert && valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
            if ((touch || insert) && (IDX_W'(i) == tgt_idx_ff)) begin
               rank_in[i]  = '0;
               valid_in[i] = 1'b1;
            end
         end
      end
   end

   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_ready);
   assign sts.out_free = ~rsp_valid_ff | rsp_ready;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= valid_in[i];
            rank_ff[i]  <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
      if (cmd.match) begin
         hit_ff      <= hit_in;
         evict_ff    <= evict_in;
         tgt_idx_ff  <= tgt_idx_in;
         tgt_rank_ff <= tgt_rank_in;
      end
      rsp_ff <= rsp_in;
      if (wr_key) begin
         key_ff[tgt_idx_ff] <= req_ff.key;
      end
      if (wr_value) begin
         value_ff[tgt_idx_ff] <= req_ff.value;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative 16-entry key-value store with least-recently-used
// replacement; get and put requests, one response per request.
// ----------------------------------------------------------------------------
// Each item passes through a compare step and a commit step: the compare step
// checks the key against all entry lanes in parallel and picks the hit,
// victim or free lane, the commit step updates the recency ranks, writes the
// entry and loads the response register. A new item is taken in the commit
// cycle, so the next item is accepted as the last one commits while
// rsp_ready keeps the response register drained; a response stuck in that
// register holds the commit of the next item. Reset empties the store at
// once (no clearing pass) and sets the capacity to 16; capacity 0 acts as 1
// and values above 16 act as 16. Lowering the capacity drops no entries;
// later inserts replace the least recent entry in place.
// ----------------------------------------------------------------------------
module lru_key_value_cache
   import lkvc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lkvc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- test/lru_key_value_cache_tb.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Self-checking bench for the lru key-value cache. A behavioral copy of the
// store (keys, values, recency ranks, fill count, capacity) predicts every
// response. Directed gets and puts cover the field extremes and the capacity
// corner cases. Random phases at several capacities follow. Both handshakes
// idle at random, and one long response stall backs up the request side.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
   import lkvc_pkg::*;

   localparam int LONG_HOLD_CYCLES = 200;
   localparam int MAX_REPORTS      = 10;
   localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_payload;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   // behavioral copy of the store
   logic signed [DATA_W-1:0] slot_key   [ENTRIES];
   logic signed [DATA_W-1:0] slot_value [ENTRIES];
   bit                       slot_valid [ENTRIES];
   logic [RANK_W-1:0]        slot_rank  [ENTRIES];
   logic [COUNT_W-1:0]       fill_count;
   logic [CAP_W-1:0]         capacity_reg;

   rsp_type                  expected_rsps[$];
   logic signed [DATA_W-1:0] key_pool[$];
   int                       fail_count = 0;
   bit                       send_gaps_on = 1'b1;
   logic                     rsp_gaps_on = 1'b1;
   logic                     rsp_holding = 1'b0;
   int                       ready_gap = 0;
   event                     long_hold_go;

   lru_key_value_cache i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // store model
   // ------------------------------------------------------------------------
   function automatic void clear_store();
      for (int i = 0; i < ENTRIES; i++) begin
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_valid[i] = 1'b0;
         slot_rank[i]  = '0;
      end
      fill_count   = '0;
      capacity_reg = CAP_RESET;
   endfunction

   // entry s becomes most recent, younger valid entries age by one
   function automatic void make_recent(input int s);
      logic [RANK_W-1:0] old_rank;
      old_rank = slot_rank[s];
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i] && i != s && slot_rank[i] < old_rank) begin
            slot_rank[i] = slot_rank[i] + 1'b1;
         end
      end
      slot_rank[s] = '0;
   endfunction

   function automatic rsp_type cache_lookup(input req_type r);
      rsp_type res;
      int      found;
      int      target;
      int      eff_cap;
      found = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && slot_valid[i] && slot_key[i] == r.key) begin
            found = i;
         end
      end
      res.hit        = (found >= 0);
      res.read_value = PUT_VALUE;
      if (r.mode == MODE_GET) begin
         if (found >= 0) begin
            res.read_value = slot_value[found];
            make_recent(found);
         end else begin
            res.read_value = MISS_VALUE;
         end
         return res;
      end
      if (found >= 0) begin
         slot_value[found] = r.value;
         make_recent(found);
         return res;
      end
      eff_cap = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
      if (fill_count >= eff_cap) begin
         // replace the least recent entry in place
         target = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && slot_rank[i] > slot_rank[target]) begin
               target = i;
            end
         end
         slot_key[target]   = r.key;
         slot_value[target] = r.value;
         slot_valid[target] = 1'b1;
         make_recent(target);
      end else begin
         target = -1;
         for (int i = 0; i < ENTRIES; i++) begin
            if (target < 0 && !slot_valid[i]) begin
               target = i;
            end
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i]) begin
               slot_rank[i] = slot_rank[i] + 1'b1;
            end
         end
         slot_key[target]   = r.key;
         slot_value[target] = r.value;
         slot_valid[target] = 1'b1;
         slot_rank[target]  = '0;
         fill_count         = fill_count + 1'b1;
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   task automatic send_request(input req_type r);
      if (send_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(cache_lookup(r));
   endtask

   task automatic do_put(input logic signed [DATA_W-1:0] k, input logic signed [DATA_W-1:0] v);
      req_type r;
      r.mode  = MODE_PUT;
      r.key   = k;
      r.value = v;
      send_request(r);
   endtask

   task automatic do_get(input logic signed [DATA_W-1:0] k);
      req_type r;
      r.mode  = MODE_GET;
      r.key   = k;
      r.value = $urandom;
      send_request(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      wait_drained();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      capacity_reg = cap;
      csr_wr_en   <= 1'b0;
   endtask

   function automatic void new_key_pool(input int n);
      key_pool = {KEY_MAX, KEY_MIN, 32'sd0, -32'sd1};
      repeat (n) key_pool.push_back($urandom);
   endfunction

   // mostly keys from the pool so hits and evictions happen, some fresh ones
   function automatic req_type random_request();
      req_type r;
      r.mode = $urandom_range(0, 1) ? MODE_PUT : MODE_GET;
      if ($urandom_range(0, 9) == 0) begin
         r.key = $urandom;
      end else begin
         r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      r.value = $urandom;
      return r;
   endfunction

   task automatic random_phase(input logic [CAP_W-1:0] cap, input int count, input int pool_n);
      write_capacity(cap);
      new_key_pool(pool_n);
      send_gaps_on = ($urandom_range(0, 3) != 0);
      rsp_gaps_on <= ($urandom_range(0, 3) != 0);
      repeat (count) send_request(random_request());
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_gap <= 0;
      end else if (rsp_holding) begin
         rsp_ready <= 1'b0;
      end else if (ready_gap != 0) begin
         ready_gap <= ready_gap - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_gaps_on && $urandom_range(0, 7) == 0) begin
         ready_gap <= $urandom_range(0, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always begin
      @(long_hold_go);
      rsp_holding <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      rsp_holding <= 1'b0;
   end

   task automatic log_mismatch(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("mismatch on %s: expected %h, got %h", what, want, got);
      end
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("response with no request pending: hit %b value %h",
                        rsp_payload.hit, rsp_payload.read_value);
            end
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload.hit !== want.hit) begin
               log_mismatch("hit", DATA_W'(want.hit), DATA_W'(rsp_payload.hit));
            end
            if (rsp_payload.read_value !== want.read_value) begin
               log_mismatch("read_value", want.read_value, rsp_payload.read_value);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_directed_ops();
      do_get(32'sd0);
      do_get(KEY_MAX);
      do_put(KEY_MAX, KEY_MIN);
      do_put(KEY_MIN, KEY_MAX);
      do_put(32'sd0, -32'sd1);
      do_put(-32'sd1, 32'sd0);
      do_get(KEY_MAX);
      do_get(KEY_MIN);
      do_get(32'sd0);        // stored value equals the miss value
      do_get(-32'sd1);
      do_put(KEY_MAX, 32'sh5A5A_A5A5);
      do_get(KEY_MAX);
      do_get(32'sd1);
      do_put(32'sh0F0F_F0F0, -32'sd1);
      do_get(32'sh0F0F_F0F0);
      do_get(32'sh7FFF_FFFE);
   endtask

   // capacity of one, zero (acts as one) and above the entry count
   task automatic test_capacity_limits();
      logic [CAP_W-1:0] caps[4];
      caps = '{5'd1, 5'd0, 5'd31, 5'd17};
      foreach (caps[c]) begin
         write_capacity(caps[c]);
         for (int i = 0; i < 18; i++) do_put(32'sh1000_0000 + c * 64 + i, $urandom);
         for (int i = 0; i < 3; i++) do_get(32'sh1000_0000 + c * 64 + i);
         for (int i = 15; i < 18; i++) do_get(32'sh1000_0000 + c * 64 + i);
      end
   endtask

   // full store, then capacity lowered below the fill count
   task automatic test_shrink_below_fill();
      write_capacity(5'd16);
      for (int i = 0; i < 16; i++) do_put(32'sh2000_0000 + i, $urandom);
      do_get(32'sh2000_0000);
      do_get(32'sh2000_0003);
      write_capacity(5'd4);
      for (int i = 0; i < 6; i++) do_put(32'sh2100_0000 + i, $urandom);
      for (int i = 0; i < 16; i += 3) do_get(32'sh2000_0000 + i);
      do_get(32'sh2100_0005);
   endtask

   task automatic test_random_mix();
      random_phase(5'd16, 60, 24);
      random_phase(5'd1, 100, 3);
      random_phase(5'd8, 60, 12);
      random_phase(5'd0, 60, 3);
      random_phase(5'($urandom_range(2, 15)), 120, 20);
      random_phase(5'($urandom_range(0, 31)), 120, 26);
   endtask

   // responses held off while requests keep coming
   task automatic test_input_stall();
      write_capacity(5'd12);
      new_key_pool(16);
      send_gaps_on = 1'b0;
      -> long_hold_go;
      repeat (40) send_request(random_request());
      send_gaps_on = 1'b1;
   endtask

   task automatic test_quiet_tail();
      write_capacity(5'd16);
      new_key_pool(22);
      send_gaps_on = 1'b0;
      rsp_gaps_on <= 1'b0;
      repeat (120) send_request(random_request());
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      clear_store();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_ops();
      test_capacity_limits();
      test_shrink_below_fill();
      test_random_mix();
      test_input_stall();
      test_quiet_tail();

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/lkvc_pkg.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_datapath.sv
rtl/lru_key_value_cache.sv
test/lru_key_value_cache_tb.sv
